// ----- rtl/ircl_pkg.sv -----
// ============================================================================
// ircl_pkg
// Shared types, widths and codes for the infrared code learn and match core.
// ============================================================================
`default_nettype none

package ircl_pkg;

    localparam int ATTEMPTS = 3;
    localparam int CNT_W    = $clog2(ATTEMPTS + 1);
    localparam int IDX_W    = $clog2(ATTEMPTS);

    localparam int IN_DATA_W  = 112;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MINBITS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNKNOWN = 3'd4;

    localparam logic [6:0]  MIN_BITS_RST = 7'd20;
    localparam logic [15:0] WINDOW_RST   = 16'd500;
    localparam logic [15:0] TIMEOUT_RST  = 16'd10000;
    localparam logic [7:0]  UNKNOWN_RST  = 8'hFF;

    localparam logic [3:0] ST_NOTHING    = 4'd0;
    localparam logic [3:0] ST_TIMEOUT    = 4'd1;
    localparam logic [3:0] ST_TOO_SOON   = 4'd2;
    localparam logic [3:0] ST_REPEAT     = 4'd3;
    localparam logic [3:0] ST_SHORT      = 4'd4;
    localparam logic [3:0] ST_UNKNOWN    = 4'd5;
    localparam logic [3:0] ST_ACCEPTED   = 4'd6;
    localparam logic [3:0] ST_REGISTERED = 4'd7;
    localparam logic [3:0] ST_MISMATCH   = 4'd8;
    localparam logic [3:0] ST_MATCH      = 4'd9;
    localparam logic [3:0] ST_NO_MATCH   = 4'd10;

    typedef struct packed {
        logic        has_frame;
        logic [31:0] now_ms;
        logic [7:0]  protocol;
        logic [63:0] code_value;
        logic [6:0]  bit_count;
        logic        is_repeat;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  protocol;
        logic [6:0]  bits;
        logic [63:0] value;
    } ir_code_t;

endpackage

`default_nettype wire

// ----- rtl/ir_code_learn_and_match_core.sv -----
// ============================================================================
// ir_code_learn_and_match_core
// Learns a remote-control code from decoded frames and watches for it.
// ============================================================================
// Flow: input register, then result register (m_axis_tvalid); a result held by
//   m_axis_tready low holds the item behind it.
// Throughput: one item per cycle unless m_axis_tready stalls; the input and result
//   registers let a new item enter while a finished result waits to be taken.
// Reset: rst_n clears all control state and loads the register defaults;
//   no code is registered after reset.
`default_nettype none

module ir_code_learn_and_match_core
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // now_ms[31:0], protocol[39:32], code_value[103:40], bit_count[110:104], zero
    input  wire logic [ircl_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // has_frame[0], is_repeat[1]
    input  wire logic [ircl_pkg::IN_USER_W-1:0]    s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // status[3:0], attempts_held[5:4], code_registered[6], zero[7]
    output logic [ircl_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [ircl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ircl_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic        mode_reg;
    logic [6:0]  min_bits_reg;
    logic [15:0] window_reg;
    logic [15:0] timeout_reg;
    logic [7:0]  unknown_reg;

    logic                 in_valid_reg;
    ircl_pkg::in_item_t   in_item_reg;
    logic                 out_valid_reg;
    logic [ircl_pkg::OUT_DATA_W-1:0] out_data_reg;

    ircl_pkg::ir_code_t   cand_reg [ircl_pkg::ATTEMPTS];
    ircl_pkg::ir_code_t   stored_reg;
    logic                 stored_valid_reg;
    logic [ircl_pkg::CNT_W-1:0] count_reg;
    logic [31:0]          last_receive_reg;
    logic [31:0]          last_accept_reg;

    logic                 advance;
    ircl_pkg::ir_code_t   frame_code;
    ircl_pkg::ir_code_t   entry [ircl_pkg::ATTEMPTS];
    logic [31:0]          since_receive;
    logic [31:0]          since_accept;
    logic                 timed_out;
    logic                 too_soon;
    logic [ircl_pkg::IDX_W-1:0] wr_idx;
    logic                 all_same;

    logic [3:0]           status_next;
    logic                 cand_we;
    logic                 stored_valid_next;
    logic                 stored_we;
    logic [ircl_pkg::CNT_W-1:0] count_next;
    logic [31:0]          last_receive_next;
    logic [31:0]          last_accept_next;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign cfg_ready     = 1'b1;

    assign frame_code.protocol = in_item_reg.protocol;
    assign frame_code.bits     = in_item_reg.bit_count;
    assign frame_code.value    = in_item_reg.code_value;

    assign since_receive = in_item_reg.now_ms - last_receive_reg;
    assign since_accept  = in_item_reg.now_ms - last_accept_reg;
    assign timed_out     = (count_reg != '0) && (since_receive > {16'd0, timeout_reg});
    assign too_soon      = since_accept < {16'd0, window_reg};
    assign wr_idx        = (count_reg >= ircl_pkg::CNT_W'(ircl_pkg::ATTEMPTS))
                           ? '0 : count_reg[ircl_pkg::IDX_W-1:0];

    always_comb
    begin
        for (int i = 0; i < ircl_pkg::ATTEMPTS; i++)
        begin
            entry[i] = (wr_idx == ircl_pkg::IDX_W'(i)) ? frame_code : cand_reg[i];
        end
        all_same = 1'b1;
        for (int i = 1; i < ircl_pkg::ATTEMPTS; i++)
        begin
            if (entry[i] != entry[0])
            begin
                all_same = 1'b0;
            end
        end
    end

    always_comb
    begin
        status_next       = ircl_pkg::ST_NOTHING;
        cand_we           = 1'b0;
        stored_we         = 1'b0;
        stored_valid_next = stored_valid_reg;
        count_next        = count_reg;
        last_receive_next = last_receive_reg;
        last_accept_next  = last_accept_reg;
        if (!mode_reg)
        begin
            if (timed_out)
            begin
                status_next       = ircl_pkg::ST_TIMEOUT;
                count_next        = '0;
                last_accept_next  = '0;
                last_receive_next = in_item_reg.now_ms;
            end
            else if (!in_item_reg.has_frame)
            begin
                status_next = ircl_pkg::ST_NOTHING;
            end
            else if (too_soon)
            begin
                status_next = ircl_pkg::ST_TOO_SOON;
            end
            else if (in_item_reg.is_repeat)
            begin
                status_next = ircl_pkg::ST_REPEAT;
            end
            else if (in_item_reg.bit_count < min_bits_reg)
            begin
                status_next = ircl_pkg::ST_SHORT;
            end
            else if (in_item_reg.protocol == unknown_reg)
            begin
                status_next = ircl_pkg::ST_UNKNOWN;
            end
            else
            begin
                cand_we           = 1'b1;
                last_receive_next = in_item_reg.now_ms;
                last_accept_next  = in_item_reg.now_ms;
                if (wr_idx != ircl_pkg::IDX_W'(ircl_pkg::ATTEMPTS - 1))
                begin
                    status_next = ircl_pkg::ST_ACCEPTED;
                    count_next  = ircl_pkg::CNT_W'(wr_idx) + ircl_pkg::CNT_W'(1);
                end
                else if (all_same)
                begin
                    status_next       = ircl_pkg::ST_REGISTERED;
                    stored_we         = 1'b1;
                    stored_valid_next = 1'b1;
                    count_next        = '0;
                end
                else
                begin
                    status_next      = ircl_pkg::ST_MISMATCH;
                    count_next       = '0;
                    last_accept_next = '0;
                end
            end
        end
        else if (stored_valid_reg && in_item_reg.has_frame)
        begin
            if (in_item_reg.is_repeat)
            begin
                status_next = ircl_pkg::ST_REPEAT;
            end
            else if (too_soon)
            begin
                status_next = ircl_pkg::ST_TOO_SOON;
            end
            else if (frame_code == stored_reg)
            begin
                status_next      = ircl_pkg::ST_MATCH;
                last_accept_next = in_item_reg.now_ms;
            end
            else
            begin
                status_next = ircl_pkg::ST_NO_MATCH;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= 1'b0;
            min_bits_reg <= ircl_pkg::MIN_BITS_RST;
            window_reg   <= ircl_pkg::WINDOW_RST;
            timeout_reg  <= ircl_pkg::TIMEOUT_RST;
            unknown_reg  <= ircl_pkg::UNKNOWN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ircl_pkg::REG_MODE:    mode_reg     <= cfg_data[0];
                ircl_pkg::REG_MINBITS: min_bits_reg <= cfg_data[6:0];
                ircl_pkg::REG_WINDOW:  window_reg   <= cfg_data;
                ircl_pkg::REG_TIMEOUT: timeout_reg  <= cfg_data;
                ircl_pkg::REG_UNKNOWN: unknown_reg  <= cfg_data[7:0];
                default:               ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            stored_valid_reg <= 1'b0;
            count_reg        <= '0;
            last_receive_reg <= '0;
            last_accept_reg  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg    <= 1'b1;
                stored_valid_reg <= stored_valid_next;
                count_reg        <= count_next;
                last_receive_reg <= last_receive_next;
                last_accept_reg  <= last_accept_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_item_reg.has_frame  <= s_axis_tuser[0];
            in_item_reg.is_repeat  <= s_axis_tuser[1];
            in_item_reg.now_ms     <= s_axis_tdata[31:0];
            in_item_reg.protocol   <= s_axis_tdata[39:32];
            in_item_reg.code_value <= s_axis_tdata[103:40];
            in_item_reg.bit_count  <= s_axis_tdata[110:104];
        end
        if (advance)
        begin
            out_data_reg <= {1'b0, stored_valid_next, 2'(count_next), status_next};
            if (cand_we)
            begin
                cand_reg[wr_idx] <= frame_code;
            end
            if (stored_we)
            begin
                stored_reg <= entry[0];
            end
        end
    end

    a_stored_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(stored_valid_reg))
        else $error("registered code lost");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < ircl_pkg::CNT_W'(ircl_pkg::ATTEMPTS))
        else $error("attempt count overran");

    a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced item produced no result");

    a_registered_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg[3:0] == ircl_pkg::ST_REGISTERED)
        |-> (out_data_reg[6] && out_data_reg[5:4] == 2'd0))
        else $error("registered result with inconsistent flags");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |=> $stable(out_data_reg))
        else $error("stalled result changed");

endmodule

`default_nettype wire
